### rtl/core/ovr_pkg.sv
// ----------------------------------------------------------------------------
// ovr_pkg
// shared constants, operation codes and control types of the perceptron ring
// ----------------------------------------------------------------------------
package ovr_pkg;

  localparam int unsigned DefUnits    = 10;
  localparam int unsigned DefFeatures = 7;
  localparam int unsigned MaxFeatures = 7;

  localparam int unsigned WeightW = 32;
  localparam int unsigned FeatW   = 16;
  localparam int unsigned RateW   = 16;
  localparam int unsigned LabelW  = 4;
  localparam int unsigned UidxW   = 4;
  localparam int unsigned WidxW   = 3;
  localparam int unsigned ActW    = 5;
  localparam int unsigned ProdW   = 48;
  localparam int unsigned SumW    = 51;
  localparam int unsigned BestW   = 48;
  localparam int unsigned DeltaW  = 25;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [CfgIdxW-1:0] CfgLearnRate   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgActiveUnits = 4'd1;

  localparam logic [RateW-1:0] RateReset   = 16'd6554;
  localparam logic [ActW-1:0]  ActiveReset = 5'd10;

  typedef enum logic [1:0] {
    OpLoad     = 2'd0,
    OpRead     = 2'd1,
    OpTrain    = 2'd2,
    OpClassify = 2'd3
  } op_e;

  typedef struct packed {
    logic               shift;
    logic               load;
    logic [WidxW-1:0]   widx;
    logic [WeightW-1:0] wval;
    logic [LabelW-1:0]  label;
  } cell_ctrl_t;

  typedef struct packed {
    logic                   en;
    logic                   first;
    logic                   upd;
    logic signed [SumW-1:0] sum;
    logic [LabelW-1:0]      label;
  } pe_stat_t;

endpackage

### rtl/core/ovr_cell.sv
// ----------------------------------------------------------------------------
// ovr_cell
// one ring cell: weights and label of one unit, shifted on from its neighbor
// ----------------------------------------------------------------------------
module ovr_cell import ovr_pkg::*; #(
  parameter int unsigned      NumFeatures = DefFeatures,
  parameter logic [LabelW-1:0] ResetLabel = '0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cell_ctrl_t                          ctrl_i,
  input  logic                                sel_i,
  input  logic [NumFeatures-1:0][WeightW-1:0] w_i,
  input  logic [LabelW-1:0]                   label_i,
  output logic [NumFeatures-1:0][WeightW-1:0] w_o,
  output logic [LabelW-1:0]                   label_o
);

  logic [NumFeatures-1:0][WeightW-1:0] w_d, w_q;
  logic [LabelW-1:0]                   label_d, label_q;

  always_comb begin
    w_d     = w_q;
    label_d = label_q;
    if (ctrl_i.shift) begin
      w_d     = w_i;
      label_d = label_i;
    end else if (ctrl_i.load && sel_i) begin
      label_d = ctrl_i.label;
      for (int j = 0; j < NumFeatures; j++) begin
        if (ctrl_i.widx == WidxW'(j)) begin
          w_d[j] = ctrl_i.wval;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= '0;
      label_q <= ResetLabel;
    end else begin
      w_q     <= w_d;
      label_q <= label_d;
    end
  end

  assign w_o     = w_q;
  assign label_o = label_q;

endmodule

### rtl/core/ovr_pe.sv
// ----------------------------------------------------------------------------
// ovr_pe
// ring link that scores a unit: products, sum, then perceptron update
// ----------------------------------------------------------------------------
module ovr_pe import ovr_pkg::*; #(
  parameter int unsigned NumFeatures = DefFeatures
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                shift_i,
  input  logic                                en_i,
  input  logic                                first_i,
  input  logic                                train_i,
  input  logic [LabelW-1:0]                   item_label_i,
  input  logic [RateW-1:0]                    rate_i,
  input  logic [NumFeatures-1:0][FeatW-1:0]   feat_i,
  input  logic [NumFeatures-1:0][WeightW-1:0] w_i,
  input  logic [LabelW-1:0]                   label_i,
  output logic [NumFeatures-1:0][WeightW-1:0] w_o,
  output logic [LabelW-1:0]                   label_o,
  output pe_stat_t                            stat_o
);

  logic [NumFeatures-1:0][DeltaW-1:0]  delta_q;
  logic signed [RateW+FeatW:0]         dprod [NumFeatures];
  logic [NumFeatures-1:0][ProdW-1:0]   prod_q;
  logic [NumFeatures-1:0][WeightW-1:0] pw_q, qw_q;
  logic [LabelW-1:0]                   plabel_q, qlabel_q;
  logic                                pen_q, pfirst_q, qen_q, qfirst_q;
  logic signed [SumW-1:0]              sum_d, sum_q;
  logic                                match, upd;

  always_comb begin
    for (int j = 0; j < NumFeatures; j++) begin
      dprod[j] = $signed({1'b0, rate_i}) * $signed(feat_i[j]);
    end
  end

  // step per feature, floor of rate * feature / 256
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NumFeatures; j++) begin
      delta_q[j] <= dprod[j][DeltaW+7:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int j = 0; j < NumFeatures; j++) begin
        prod_q[j] <= ProdW'($signed(feat_i[j]) * $signed(w_i[j]));
      end
      pw_q     <= w_i;
      plabel_q <= label_i;
      sum_q    <= sum_d;
      qw_q     <= pw_q;
      qlabel_q <= plabel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q    <= 1'b0;
      pfirst_q <= 1'b0;
      qen_q    <= 1'b0;
      qfirst_q <= 1'b0;
    end else if (shift_i) begin
      pen_q    <= en_i;
      pfirst_q <= first_i;
      qen_q    <= pen_q;
      qfirst_q <= pfirst_q;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int j = 0; j < NumFeatures; j++) begin
      sum_d = sum_d + SumW'($signed(prod_q[j]));
    end
  end

  assign match = (qlabel_q == item_label_i);
  assign upd   = qen_q && train_i && (match ? (sum_q <= 0) : (sum_q >= 0));

  always_comb begin
    logic signed [WeightW:0] nw;
    nw = '0;
    for (int j = 0; j < NumFeatures; j++) begin
      w_o[j] = qw_q[j];
      if (upd) begin
        if (match) begin
          nw = $signed({qw_q[j][WeightW-1], qw_q[j]}) + (WeightW+1)'($signed(delta_q[j]));
        end else begin
          nw = $signed({qw_q[j][WeightW-1], qw_q[j]}) - (WeightW+1)'($signed(delta_q[j]));
        end
        if (nw[WeightW] != nw[WeightW-1]) begin
          w_o[j] = nw[WeightW] ? {1'b1, {(WeightW-1){1'b0}}} : {1'b0, {(WeightW-1){1'b1}}};
        end else begin
          w_o[j] = nw[WeightW-1:0];
        end
      end
    end
  end

  assign label_o      = qlabel_q;
  assign stat_o.en    = qen_q;
  assign stat_o.first = qfirst_q;
  assign stat_o.upd   = upd;
  assign stat_o.sum   = sum_q;
  assign stat_o.label = qlabel_q;

endmodule

### rtl/core/one_vs_rest_perceptron_unit.sv
// ----------------------------------------------------------------------------
// one_vs_rest_perceptron_unit
// one-vs-rest perceptron: units held in a rotating ring of cells
//
//   channel | direction | handshake           | contents
//   in      | input     | in_valid/in_ready   | operation, indexes, weight, features
//   out     | output    | out_valid/out_ready | guess, best sum, count, readback
//   cfg     | input     | cfg_valid/cfg_ready | register index and data
//
// load and read do not rotate the ring; train and classify rotate the ring once,
// through the NUM_UNITS cells and the two extra ring links (the scoring stages)
// no item is accepted while one is in work or a result waits to be taken
// reset puts weights to zero and labels to the unit index, no clearing pass
// ----------------------------------------------------------------------------
module one_vs_rest_perceptron_unit import ovr_pkg::*; #(
  parameter int unsigned NUM_UNITS    = DefUnits,
  parameter int unsigned NUM_FEATURES = DefFeatures
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                operation_i,
  input  logic [UidxW-1:0]          unit_index_i,
  input  logic [WidxW-1:0]          weight_index_i,
  input  logic signed [WeightW-1:0] weight_value_i,
  input  logic [LabelW-1:0]         class_label_i,
  input  logic signed [FeatW-1:0]   feature_0_i,
  input  logic signed [FeatW-1:0]   feature_1_i,
  input  logic signed [FeatW-1:0]   feature_2_i,
  input  logic signed [FeatW-1:0]   feature_3_i,
  input  logic signed [FeatW-1:0]   feature_4_i,
  input  logic signed [FeatW-1:0]   feature_5_i,
  input  logic signed [FeatW-1:0]   feature_6_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [LabelW-1:0]         guess_class_o,
  output logic                      guess_valid_o,
  output logic signed [BestW-1:0]   best_sum_o,
  output logic [ActW-1:0]           correct_units_o,
  output logic signed [WeightW-1:0] read_weight_o,
  output logic [LabelW-1:0]         read_label_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [RateW-1:0]          cfg_data_i
);

  localparam int unsigned RingLen = NUM_UNITS + 2;
  localparam int unsigned TW      = $clog2(RingLen + 1);

  logic [RateW-1:0] rate_q;
  logic [ActW-1:0]  active_q, act_eff;

  logic            busy_q;
  logic [TW-1:0]   t_q;
  op_e             op_q;
  logic [LabelW-1:0] lbl_q;
  logic [NUM_FEATURES-1:0][FeatW-1:0] feat_q;
  logic [MaxFeatures-1:0][FeatW-1:0]  feat_all;

  logic signed [SumW-1:0] best_d, best_q;
  logic [LabelW-1:0]      blab_d, blab_q;
  logic                   have_d, have_q;
  logic [ActW-1:0]        cnt_d, cnt_q;

  logic                      out_valid_q;
  logic [LabelW-1:0]         guess_class_q, read_label_q;
  logic                      guess_valid_q;
  logic signed [BestW-1:0]   best_sum_q;
  logic [ActW-1:0]           correct_q;
  logic signed [WeightW-1:0] read_weight_q;

  logic [NUM_UNITS-1:0][NUM_FEATURES-1:0][WeightW-1:0] cw;
  logic [NUM_UNITS-1:0][LabelW-1:0]                    cl;
  logic [NUM_FEATURES-1:0][WeightW-1:0]                pe_w;
  logic [LabelW-1:0]                                   pe_l;
  logic [NUM_UNITS-1:0]                                sel;
  cell_ctrl_t                                          ctrl;
  pe_stat_t                                            stat;

  logic                      accept, finish;
  logic [WeightW-1:0]        rd_w;
  logic [LabelW-1:0]         rd_l;
  logic signed [BestW-1:0]   best_sat;

  assign in_ready_o  = !busy_q && !out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign act_eff     = (active_q > ActW'(NUM_UNITS)) ? ActW'(NUM_UNITS) : active_q;
  assign finish      = busy_q && (t_q == TW'(RingLen - 1));

  assign feat_all = {feature_6_i, feature_5_i, feature_4_i, feature_3_i,
                     feature_2_i, feature_1_i, feature_0_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RateReset;
      active_q <= ActiveReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgLearnRate) begin
        rate_q <= cfg_data_i;
      end else if (cfg_index_i == CfgActiveUnits) begin
        active_q <= cfg_data_i[ActW-1:0];
      end
    end
  end

  // cell control: ring shift while busy, write port for loads
  always_comb begin
    ctrl.shift = busy_q;
    ctrl.load  = accept && (op_e'(operation_i) == OpLoad);
    ctrl.widx  = weight_index_i;
    ctrl.wval  = weight_value_i;
    ctrl.label = class_label_i;
    for (int u = 0; u < NUM_UNITS; u++) begin
      sel[u] = (unit_index_i == UidxW'(u));
    end
  end

  for (genvar u = 0; u < NUM_UNITS; u++) begin : g_ring
    logic [NUM_FEATURES-1:0][WeightW-1:0] nw;
    logic [LabelW-1:0]                    nl;
    if (u == NUM_UNITS - 1) begin : g_tail
      assign nw = pe_w;
      assign nl = pe_l;
    end else begin : g_mid
      assign nw = cw[u+1];
      assign nl = cl[u+1];
    end
    ovr_cell #(
      .NumFeatures(NUM_FEATURES),
      .ResetLabel (LabelW'(u))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .sel_i  (sel[u]),
      .w_i    (nw),
      .label_i(nl),
      .w_o    (cw[u]),
      .label_o(cl[u])
    );
  end

  ovr_pe #(
    .NumFeatures(NUM_FEATURES)
  ) u_pe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (busy_q),
    .en_i        (ActW'(t_q) < act_eff),
    .first_i     (t_q == '0),
    .train_i     (op_q == OpTrain),
    .item_label_i(lbl_q),
    .rate_i      (rate_q),
    .feat_i      (feat_q),
    .w_i         (cw[0]),
    .label_i     (cl[0]),
    .w_o         (pe_w),
    .label_o     (pe_l),
    .stat_o      (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      t_q    <= '0;
    end else if (accept && (op_e'(operation_i) == OpTrain ||
                            op_e'(operation_i) == OpClassify)) begin
      busy_q <= 1'b1;
      t_q    <= '0;
    end else if (busy_q) begin
      busy_q <= !finish;
      t_q    <= t_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      lbl_q <= class_label_i;
      for (int j = 0; j < NUM_FEATURES; j++) begin
        feat_q[j] <= feat_all[j];
      end
    end
  end

  // best unit and correct count, one ring position per cycle
  always_comb begin
    best_d = best_q;
    blab_d = blab_q;
    have_d = have_q;
    cnt_d  = cnt_q;
    if (busy_q && stat.en) begin
      if (stat.first || stat.sum > best_q) begin
        best_d = stat.sum;
        blab_d = stat.label;
      end
      have_d = 1'b1;
      if (!stat.upd) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      best_q <= '0;
      blab_q <= '0;
      have_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      best_q <= best_d;
      blab_q <= blab_d;
      have_q <= have_d;
      cnt_q  <= cnt_d;
    end
  end

  always_comb begin
    if (best_d[SumW-1:BestW-1] != {(SumW-BestW+1){best_d[SumW-1]}}) begin
      best_sat = best_d[SumW-1] ? {1'b1, {(BestW-1){1'b0}}} : {1'b0, {(BestW-1){1'b1}}};
    end else begin
      best_sat = best_d[BestW-1:0];
    end
  end

  always_comb begin
    rd_w = '0;
    rd_l = '0;
    for (int u = 0; u < NUM_UNITS; u++) begin
      if (unit_index_i == UidxW'(u)) begin
        rd_l = cl[u];
        for (int j = 0; j < NUM_FEATURES; j++) begin
          if (weight_index_i == WidxW'(j)) begin
            rd_w = cw[u][j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && (op_e'(operation_i) == OpLoad ||
                            op_e'(operation_i) == OpRead)) begin
      out_valid_q <= 1'b1;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      guess_class_q <= '0;
      guess_valid_q <= 1'b0;
      best_sum_q    <= '0;
      correct_q     <= '0;
      read_weight_q <= '0;
      read_label_q  <= '0;
      if (op_e'(operation_i) == OpRead) begin
        read_weight_q <= rd_w;
        read_label_q  <= rd_l;
      end
    end else if (finish) begin
      if (op_q == OpClassify) begin
        guess_class_q <= have_d ? blab_d : '0;
        guess_valid_q <= have_d;
        best_sum_q    <= have_d ? best_sat : '0;
      end else begin
        correct_q <= cnt_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign guess_class_o   = guess_class_q;
  assign guess_valid_o   = guess_valid_q;
  assign best_sum_o      = best_sum_q;
  assign correct_units_o = correct_q;
  assign read_weight_o   = read_weight_q;
  assign read_label_o    = read_label_q;

endmodule

### test/ovr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ovr_checker
// watches the config, input and output channels of the perceptron unit, keeps
// its own copy of weights, labels and registers, computes the expected result
// of every accepted item and compares it field by field with what comes out
// ----------------------------------------------------------------------------
module ovr_checker import ovr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [1:0]                operation_i,
  input  logic [UidxW-1:0]          unit_index_i,
  input  logic [WidxW-1:0]          weight_index_i,
  input  logic signed [WeightW-1:0] weight_value_i,
  input  logic [LabelW-1:0]         class_label_i,
  input  logic signed [FeatW-1:0]   feat_i [7],
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [LabelW-1:0]         guess_class_i,
  input  logic                      guess_valid_i,
  input  logic signed [BestW-1:0]   best_sum_i,
  input  logic [ActW-1:0]           correct_units_i,
  input  logic signed [WeightW-1:0] read_weight_i,
  input  logic [LabelW-1:0]         read_label_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [RateW-1:0]          cfg_data_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        results_o
);

  localparam int NU = 10;
  localparam int NF = 7;

  typedef struct packed {
    logic [LabelW-1:0]         guess_class;
    logic                      guess_valid;
    logic signed [BestW-1:0]   best_sum;
    logic [ActW-1:0]           correct_units;
    logic signed [WeightW-1:0] read_weight;
    logic [LabelW-1:0]         read_label;
  } verdict_t;

  logic signed [WeightW-1:0] weights [NU*NF];
  logic [LabelW-1:0]         labels [NU];
  logic [RateW-1:0]          rate;
  logic [ActW-1:0]           active;
  verdict_t                  expected_q [$];

  function automatic longint dot(int u, longint f [NF]);
    longint s;
    s = 0;
    for (int j = 0; j < NF; j++) s += f[j] * longint'(weights[u*NF+j]);
    return s;
  endfunction

  function automatic logic signed [WeightW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic perceptron_step(output verdict_t r);
    longint f [NF];
    longint s, best, d, lim;
    int act, bu, good;
    logic match;
    r = '0;
    act = (active > NU) ? NU : active;
    for (int j = 0; j < NF; j++) f[j] = longint'(feat_i[j]);
    case (op_e'(operation_i))
      OpLoad: begin
        if (unit_index_i < NU) begin
          labels[unit_index_i] = class_label_i;
          if (weight_index_i < NF) weights[unit_index_i*NF+weight_index_i] = weight_value_i;
        end
      end
      OpRead: begin
        if (unit_index_i < NU) begin
          r.read_label = labels[unit_index_i];
          if (weight_index_i < NF) r.read_weight = weights[unit_index_i*NF+weight_index_i];
        end
      end
      OpTrain: begin
        good = 0;
        for (int u = 0; u < act; u++) begin
          s = dot(u, f);
          match = (labels[u] == class_label_i);
          if ((match && s <= 0) || (!match && s >= 0)) begin
            for (int j = 0; j < NF; j++) begin
              d = (longint'(rate) * f[j]) >>> 8;
              weights[u*NF+j] = clamp32(match ? longint'(weights[u*NF+j]) + d
                                              : longint'(weights[u*NF+j]) - d);
            end
          end else good++;
        end
        r.correct_units = ActW'(good);
      end
      OpClassify: begin
        if (act > 0) begin
          lim = 64'sd1 <<< 47;
          best = dot(0, f);
          bu = 0;
          for (int u = 1; u < act; u++) begin
            s = dot(u, f);
            if (s > best) begin
              best = s;
              bu = u;
            end
          end
          if (best > lim - 1) best = lim - 1;
          if (best < -lim) best = -lim;
          r.guess_class = labels[bu];
          r.guess_valid = 1'b1;
          r.best_sum = best[47:0];
        end
      end
    endcase
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t r, e;
    if (!rst_ni) begin
      for (int i = 0; i < NU*NF; i++) weights[i] = '0;
      for (int u = 0; u < NU; u++) labels[u] = u[3:0];
      rate = RateReset;
      active = ActiveReset;
      expected_q.delete();
      errors_o = 0;
      results_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgLearnRate) rate = cfg_data_i;
        else if (cfg_index_i == CfgActiveUnits) active = cfg_data_i[ActW-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          if (guess_class_i !== e.guess_class) report("guess_class", guess_class_i, e.guess_class);
          if (guess_valid_i !== e.guess_valid) report("guess_valid", guess_valid_i, e.guess_valid);
          if (best_sum_i !== e.best_sum) report("best_sum", best_sum_i, e.best_sum);
          if (correct_units_i !== e.correct_units)
            report("correct_units", correct_units_i, e.correct_units);
          if (read_weight_i !== e.read_weight) report("read_weight", read_weight_i, e.read_weight);
          if (read_label_i !== e.read_label) report("read_label", read_label_i, e.read_label);
        end
      end
      if (in_valid_i && in_ready_i) begin
        perceptron_step(r);
        expected_q.push_back(r);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the one-vs-rest perceptron unit: directed corner
// items, then mixed load/read/train/classify sessions under several rate and unit
// count settings, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb;
  import ovr_pkg::*;

  localparam int WatchLimit = 20000;

  logic                      clk, rst_n;
  logic                      in_valid, in_ready;
  logic [1:0]                operation;
  logic [UidxW-1:0]          unit_index;
  logic [WidxW-1:0]          weight_index;
  logic signed [WeightW-1:0] weight_value;
  logic [LabelW-1:0]         class_label;
  logic signed [FeatW-1:0]   feat [7];
  logic                      out_valid, out_ready;
  logic [LabelW-1:0]         guess_class;
  logic                      guess_valid;
  logic signed [BestW-1:0]   best_sum;
  logic [ActW-1:0]           correct_units;
  logic signed [WeightW-1:0] read_weight;
  logic [LabelW-1:0]         read_label;
  logic                      cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0]        cfg_index;
  logic [RateW-1:0]          cfg_data;
  int                        errors, pending, results;
  int                        idle_cycles, sent, long_hold;
  logic                      stimulus_done;

  one_vs_rest_perceptron_unit u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .unit_index_i(unit_index), .weight_index_i(weight_index),
    .weight_value_i(weight_value), .class_label_i(class_label),
    .feature_0_i(feat[0]), .feature_1_i(feat[1]), .feature_2_i(feat[2]),
    .feature_3_i(feat[3]), .feature_4_i(feat[4]), .feature_5_i(feat[5]),
    .feature_6_i(feat[6]), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .guess_class_o(guess_class), .guess_valid_o(guess_valid), .best_sum_o(best_sum),
    .correct_units_o(correct_units), .read_weight_o(read_weight),
    .read_label_o(read_label), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  ovr_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(operation), .unit_index_i(unit_index), .weight_index_i(weight_index),
    .weight_value_i(weight_value), .class_label_i(class_label), .feat_i(feat),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .guess_class_i(guess_class),
    .guess_valid_i(guess_valid), .best_sum_i(best_sum), .correct_units_i(correct_units),
    .read_weight_i(read_weight), .read_label_i(read_label), .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [FeatW-1:0] rand_feat(int mode);
    case (mode)
      0: return FeatW'($urandom());
      1: return FeatW'($signed(11'($urandom())));
      default: return ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
    endcase
  endfunction

  // receiver: random stalls, and one long hold-off while items keep coming
  initial begin
    int g;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_ready <= 1'b0;
        long_hold--;
      end else if (out_ready && !out_valid) begin
        out_ready <= 1'b1;
      end else begin
        g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (g > 0) begin
          out_ready <= 1'b0;
          for (int i = 0; i < g; i++) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send(logic [1:0] op, int ui, int wi, logic [31:0] wv, int lbl, int fmode);
    int g;
    g = (sent % 97 < 30) ? 0 : gap_len();
    for (int i = 0; i < g; i++) @(posedge clk);
    in_valid <= 1'b1;
    operation <= op;
    unit_index <= UidxW'(ui);
    weight_index <= WidxW'(wi);
    weight_value <= wv;
    class_label <= LabelW'(lbl);
    for (int j = 0; j < 7; j++) feat[j] <= rand_feat(fmode);
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    sent++;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= RateW'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // a session: a random mix of weight loads, reads, labelled training and classification
  task automatic session(int n, int fmode);
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      if (c < 8) send(OpLoad, $urandom_range(0, 15), $urandom_range(0, 7), $urandom(),
                      $urandom_range(0, 15), fmode);
      else if (c < 18) send(OpRead, $urandom_range(0, 15), $urandom_range(0, 7), $urandom(),
                            $urandom_range(0, 15), fmode);
      else if (c < 65) send(OpTrain, $urandom_range(0, 15), $urandom_range(0, 7), $urandom(),
                            $urandom_range(0, 11), fmode);
      else send(OpClassify, $urandom_range(0, 15), $urandom_range(0, 7), $urandom(),
                $urandom_range(0, 15), fmode);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    operation = OpLoad;
    unit_index = '0;
    weight_index = '0;
    weight_value = '0;
    class_label = '0;
    for (int j = 0; j < 7; j++) feat[j] = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgLearnRate;
    cfg_data = '0;
    sent = 0;
    long_hold = 0;
    stimulus_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, extremes, out-of-range indexes, saturation
    send(OpRead, 3, 2, 0, 0, 0);
    send(OpClassify, 0, 0, 0, 0, 0);
    send(OpLoad, 0, 0, 32'h7fffffff, 15, 2);
    send(OpLoad, 9, 6, 32'h80000000, 0, 0);
    send(OpLoad, 12, 3, 32'h12345678, 7, 0);
    send(OpLoad, 15, 7, 32'h12345678, 7, 0);
    send(OpLoad, 4, 7, 32'h55555555, 9, 0);
    send(OpRead, 0, 0, 0, 0, 0);
    send(OpRead, 9, 6, 0, 0, 0);
    send(OpRead, 4, 7, 0, 0, 0);
    send(OpRead, 15, 7, 0, 0, 0);
    send(OpRead, 10, 0, 0, 0, 0);
    send(OpTrain, 0, 0, 0, 15, 2);
    send(OpTrain, 0, 0, 0, 3, 2);
    send(OpClassify, 0, 0, 0, 0, 2);
    send(OpClassify, 0, 0, 0, 0, 0);
    send(OpTrain, 0, 0, 0, 0, 0);
    drain();
    write_reg(CfgActiveUnits, 0);
    send(OpTrain, 0, 0, 0, 1, 0);
    send(OpClassify, 0, 0, 0, 1, 0);
    drain();
    write_reg(CfgActiveUnits, 31);
    write_reg(CfgLearnRate, 65535);
    write_reg(4'd9, 3);
    send(OpTrain, 0, 0, 0, 2, 2);
    send(OpClassify, 0, 0, 0, 2, 2);
    drain();

    // long stall on the receiver while items keep coming
    long_hold = 300;
    session(30, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CfgLearnRate, 0); write_reg(CfgActiveUnits, 1); end
        1: begin write_reg(CfgLearnRate, 65535); write_reg(CfgActiveUnits, 16); end
        2: begin write_reg(CfgLearnRate, 6554); write_reg(CfgActiveUnits, 10); end
        3: begin write_reg(CfgLearnRate, 1); write_reg(CfgActiveUnits, 2); end
        default: begin
          write_reg(CfgLearnRate, $urandom_range(0, 65535));
          write_reg(CfgActiveUnits, $urandom_range(1, 16));
        end
      endcase
      session(220, (ph % 3 == 2) ? 0 : 1);
      if (ph == 6) session(10, 2);
      drain();
    end
    stimulus_done = 1'b1;
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (stimulus_done) begin
        $display("covered %0d items and %0d results over 10 register settings,",
                 sent, results);
        $display("with load/read corner indexes, saturation and a long output stall");
        if (errors == 0 && pending == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("timeout: nothing moved for %0d cycles", WatchLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
